[hdl/mos_pkg.sv]
// package: types and constants for the median of sample set block
package mos_pkg;
  localparam int MaxSamples = 64;
  localparam int AddrW = $clog2(MaxSamples);
  localparam int CntW = $clog2(MaxSamples + 1);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] median_doubled;
    logic [6:0]         sample_count;
    logic               overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_MED_RD0,
    ST_MED_RD1,
    ST_MED_DONE
  } state_t;
endpackage

[hdl/median_of_sample_set.sv]
// top level: median of a sample set, sorted store kept in a single-port ram
//
// channel | ports                        | transfer
// --------+------------------------------+------------------------------------
// input   | start, busy, in_item         | start high while busy low
// result  | out_valid, out_item          | one cycle strobe, cannot be stalled
//
// an item into an empty store is written directly and one into a full store is
// dropped; otherwise each held sample larger than it is shifted up by one
// read/write pair through the single ram port, and a last item then adds the
// median reads.
// reset clears count, drop flag and control; ram contents need no clearing.
// busy is high while an item is being placed or the median is read.
module median_of_sample_set (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mos_pkg::in_item_t  in_item,
  output logic               out_valid,
  output mos_pkg::out_item_t out_item
);

  localparam int AW = mos_pkg::AddrW;
  localparam int CW = mos_pkg::CntW;

  // sorted store, one port, registered read
  logic signed [15:0] mem [mos_pkg::MaxSamples];
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic signed [15:0] mem_wdata;
  logic signed [15:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  mos_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;      // samples held
  logic               drop_r, drop_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;          // current hole during insertion
  logic signed [15:0] samp_r, samp_nxt;
  logic               last_r, last_nxt;
  logic signed [16:0] acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  mos_pkg::out_item_t out_r, out_nxt;

  logic [CW-1:0] mid;
  assign mid = count_r >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mos_pkg::ST_IDLE;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r  <= pos_nxt;
    samp_r <= samp_nxt;
    last_r <= last_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    pos_nxt       = pos_r;
    samp_nxt      = samp_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_addr      = pos_r[AW-1:0];
    mem_wdata     = samp_r;
    case (state_r)
      mos_pkg::ST_IDLE: begin
        if (start) begin
          samp_nxt = in_item.sample;
          last_nxt = in_item.last;
          pos_nxt  = count_r;
          if (count_r == CW'(mos_pkg::MaxSamples)) begin
            // store full: drop the sample
            drop_nxt = 1'b1;
            state_nxt = in_item.last ? mos_pkg::ST_MED_RD0 : mos_pkg::ST_IDLE;
          end else if (count_r == '0) begin
            mem_we    = 1'b1;
            mem_addr  = '0;
            mem_wdata = in_item.sample;
            count_nxt = count_r + 1'b1;
            state_nxt = in_item.last ? mos_pkg::ST_MED_RD0 : mos_pkg::ST_IDLE;
          end else begin
            // read the entry below the hole
            mem_addr  = AW'(count_r - 1'b1);
            state_nxt = mos_pkg::ST_SHIFT_RD;
          end
        end
      end
      mos_pkg::ST_SHIFT_RD: begin
        // mem_rdata_r holds entry pos-1
        if (mem_rdata_r > samp_r) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_r;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = mos_pkg::ST_SHIFT_WR;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = last_r ? mos_pkg::ST_MED_RD0 : mos_pkg::ST_IDLE;
        end
      end
      mos_pkg::ST_SHIFT_WR: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = last_r ? mos_pkg::ST_MED_RD0 : mos_pkg::ST_IDLE;
        end else begin
          mem_addr  = AW'(pos_r - 1'b1);
          state_nxt = mos_pkg::ST_SHIFT_RD;
        end
      end
      mos_pkg::ST_MED_RD0: begin
        // odd count reads mid twice, even reads mid-1 then mid
        mem_addr  = count_r[0] ? AW'(mid) : AW'(mid - 1'b1);
        state_nxt = mos_pkg::ST_MED_RD1;
      end
      mos_pkg::ST_MED_RD1: begin
        mem_addr  = AW'(mid);
        acc_nxt   = 17'(mem_rdata_r);
        state_nxt = mos_pkg::ST_MED_DONE;
      end
      mos_pkg::ST_MED_DONE: begin
        out_nxt.median_doubled = acc_r + 17'(mem_rdata_r);
        out_nxt.sample_count   = 7'(count_r);
        out_nxt.overflow       = drop_r;
        out_valid_nxt = 1'b1;
        count_nxt = '0;
        drop_nxt  = 1'b0;
        state_nxt = mos_pkg::ST_IDLE;
      end
      default: state_nxt = mos_pkg::ST_IDLE;
    endcase
  end

  assign busy      = (state_r != mos_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[hdl/mos_checker.sv]
// checker: port-level assertions for the median of sample set block
module mos_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input mos_pkg::in_item_t  in_item,
  input logic               out_valid,
  input mos_pkg::out_item_t out_item
);
  // a non-last transfer never gives a result right after it
  a_no_result_non_last: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_item.last) |=> !out_valid)
    else $error("result after non-last transfer");
  // a last transfer makes the block busy
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.last) |=> busy)
    else $error("not busy after last transfer");
  // reported count is in range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.sample_count != 7'd0 && out_item.sample_count <= 7'd64))
    else $error("count out of range");
  // result strobe is a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
endmodule

bind median_of_sample_set mos_checker u_mos_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
);

[tb/sv/tb_median_of_sample_set.sv]
// testbench: median of a sample set, random and directed sets checked against a local predictor
module tb_median_of_sample_set;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  mos_pkg::in_item_t  in_item;
  logic               out_valid;
  mos_pkg::out_item_t out_item;

  median_of_sample_set DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // predictor state: the samples of the open set, kept sorted
  int                 set_samples[$];
  logic               set_dropped;
  mos_pkg::out_item_t median_queue[$];
  int                 fail_count;
  bit                 random_gaps;

  // fold one sample into the predicted set; a last sample yields a median
  function automatic void predict_median(input logic signed [15:0] smp, input logic lst);
    int pos;
    int n;
    int twice;
    mos_pkg::out_item_t exp_item;
    if (set_samples.size() >= mos_pkg::MaxSamples) begin
      set_dropped = 1'b1;
    end else begin
      // equal samples go after the ones already held
      pos = set_samples.size();
      while (pos > 0 && set_samples[pos-1] > int'(smp)) pos--;
      set_samples.insert(pos, int'(smp));
    end
    if (lst) begin
      n = set_samples.size();
      if (n % 2 == 1) twice = 2 * set_samples[n/2];
      else twice = set_samples[n/2] + set_samples[n/2 - 1];
      exp_item.median_doubled = twice[16:0];
      exp_item.sample_count   = n[6:0];
      exp_item.overflow       = set_dropped;
      median_queue.push_back(exp_item);
      set_samples.delete();
      set_dropped = 1'b0;
    end
  endfunction

  // one transfer on the input side, with an optional random gap before it;
  // start stays high after a transfer until a gap or a drain lowers it
  task automatic send_sample(input logic signed [15:0] smp, input logic lst);
    int gap;
    gap = random_gaps ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{sample: smp, last: lst};
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_median(smp, lst);
  endtask

  // result checker: every strobe is compared with the oldest prediction
  always @(posedge clk) begin
    mos_pkg::out_item_t exp_item;
    if (rst_n && out_valid) begin
      if (median_queue.size() == 0) begin
        $error("unexpected result: median_doubled %0d", out_item.median_doubled);
        fail_count++;
      end else begin
        exp_item = median_queue.pop_front();
        if (out_item.median_doubled !== exp_item.median_doubled) begin
          $error("median_doubled: expected %0d, got %0d",
                 exp_item.median_doubled, out_item.median_doubled);
          fail_count++;
        end
        if (out_item.sample_count !== exp_item.sample_count) begin
          $error("sample_count: expected %0d, got %0d",
                 exp_item.sample_count, out_item.sample_count);
          fail_count++;
        end
        if (out_item.overflow !== exp_item.overflow) begin
          $error("overflow: expected %0b, got %0b", exp_item.overflow, out_item.overflow);
          fail_count++;
        end
      end
    end
  end

  // stop sending and wait until every predicted median has come out
  task automatic drain_medians();
    start <= 1'b0;
    while (median_queue.size() != 0) @(posedge clk);
  endtask

  // extremes, single-sample sets, odd and even counts, ties
  task automatic test_directed();
    random_gaps = 1'b0;
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd5, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
    drain_medians();
  endtask

  // overfull set, its last three samples dropped, then a descending set that fills the store
  task automatic test_overflow();
    random_gaps = 1'b1;
    for (int i = 0; i < mos_pkg::MaxSamples + 3; i++)
      send_sample(16'($urandom), i == mos_pkg::MaxSamples + 2);
    for (int i = 0; i < mos_pkg::MaxSamples; i++)
      send_sample(16'(mos_pkg::MaxSamples - i), i == mos_pkg::MaxSamples - 1);
    drain_medians();
  endtask

  // random sets, mostly short, a few near or past the store depth
  task automatic test_random_sets();
    int sent;
    int len;
    logic signed [15:0] smp;
    sent = 0;
    while (sent < 1700) begin
      random_gaps = ($urandom_range(3, 0) != 0);
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(mos_pkg::MaxSamples + 4, 40)
                                        : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        // narrow ranges now and then so ties show up
        smp = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(4, 0) - 2) : 16'($urandom);
        send_sample(smp, i == len - 1);
      end
      sent += len;
      // now and then the sender holds off until all medians have come out
      if ($urandom_range(15, 0) == 0) drain_medians();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    fail_count  = 0;
    set_dropped = 1'b0;
    random_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random_sets();
    drain_medians();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit: a time-out that ends the run as failed if the tests have not finished
  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
